>>> src/tivs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tivs_pkg
// Types and constants shared by the timed ignition valve sequencer.
// ----------------------------------------------------------------------------
package tivs_pkg;

  localparam int unsigned NumValves = 2;
  localparam int unsigned AngleW    = 8;
  localparam int unsigned TimerW    = 16;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;

  // Item codes on the request channel.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RADIO = 2'd1;
  localparam logic [1:0] CMD_LINK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] REG_IGN_DELAY  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_BURN_TIME  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_SLEW_PER   = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_MAX_ANGLE  = 2'd3;

  // Reset values.
  localparam logic [TimerW-1:0] IGN_DELAY_RST = 16'd1000;
  localparam logic [TimerW-1:0] BURN_TIME_RST = 16'd15000;
  localparam logic [7:0]        SLEW_PER_RST  = 8'd25;
  localparam logic [AngleW-1:0] MAX_ANGLE_RST = 8'd180;
  localparam logic [AngleW-1:0] ANGLE_RST     = 8'd180;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_IGN_ON   = 3'd1,
    PH_OPENING  = 3'd2,
    PH_WAITING  = 3'd3,
    PH_CLOSING  = 3'd4,
    PH_COMPLETE = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        ready_req;
    logic        ignite;
    logic        valve1_request;
    logic        valve2_request;
    logic        halt;
    logic [15:0] angle1;
    logic [15:0] angle2;
    logic        link_ok;
  } in_t;

  typedef struct packed {
    logic        ignition_out;
    logic        power_out;
    logic [7:0]  valve1_position;
    logic [7:0]  valve2_position;
    logic        valve1_open;
    logic        valve2_open;
    logic        fired;
    logic        ready_status;
    logic        halt_status;
    logic [2:0]  phase;
  } out_t;

endpackage

>>> src/timed_ignition_valve_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_ignition_valve_sequencer
// Ignition and two-valve burn sequencer driven by tick, radio command and
// link-status requests, with a plain configuration write port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_stall_o   tivs_pkg::in_t
//  out       output     out_valid_o / out_stall_i tivs_pkg::out_t
//  cfg       input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One request is taken per cycle when not stalled; its result is registered
// and appears in the next cycle. All state updates in a single pass of
// compare-and-count logic. The request side stalls only while a result
// waits and out_stall_i is high. Reset is asynchronous and returns every
// register but out_q to its documented value; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_ignition_valve_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tivs_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tivs_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tivs_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [tivs_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned NV = tivs_pkg::NumValves;
  localparam int unsigned AW = tivs_pkg::AngleW;
  localparam int unsigned TW = tivs_pkg::TimerW;

  // Configuration registers.
  logic [TW-1:0] ign_delay_q, burn_time_q;
  logic [7:0]    slew_per_q;
  logic [AW-1:0] max_angle_q;

  // Sequencer state.
  tivs_pkg::phase_e phase_q, phase_d;
  logic [TW-1:0]    timer_q, timer_d;
  logic             link_q, link_d;
  logic [4:0]       flags_q, flags_d;
  logic             fired_q, fired_d;
  logic             ign_q, ign_d;
  logic [AW-1:0]    angle_q [NV];
  logic [AW-1:0]    angle_d [NV];
  logic [AW-1:0]    pos_q   [NV];
  logic [AW-1:0]    pos_d   [NV];
  logic [AW-1:0]    tgt_q   [NV];
  logic [AW-1:0]    tgt_d   [NV];
  logic [7:0]       div_q   [NV];
  logic [7:0]       div_d   [NV];

  logic           out_valid_q;
  tivs_pkg::out_t out_q, out_d;
  logic           accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_delay_q <= tivs_pkg::IGN_DELAY_RST;
      burn_time_q <= tivs_pkg::BURN_TIME_RST;
      slew_per_q  <= tivs_pkg::SLEW_PER_RST;
      max_angle_q <= tivs_pkg::MAX_ANGLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tivs_pkg::REG_IGN_DELAY: ign_delay_q <= cfg_wdata_i;
        tivs_pkg::REG_BURN_TIME: burn_time_q <= cfg_wdata_i;
        tivs_pkg::REG_SLEW_PER:  slew_per_q  <= cfg_wdata_i[7:0];
        tivs_pkg::REG_MAX_ANGLE: max_angle_q <= cfg_wdata_i[AW-1:0];
        default: ;
      endcase
    end
  end

  // Next state and result for the request at the input.
  always_comb begin
    logic [7:0]    period;
    logic [7:0]    div_inc;
    logic [4:0]    now;
    logic [4:0]    rise;
    logic [15:0]   raw [NV];
    logic [TW-1:0] timer_inc;
    logic          manual;

    phase_d = phase_q;
    timer_d = timer_q;
    link_d  = link_q;
    flags_d = flags_q;
    fired_d = fired_q;
    ign_d   = ign_q;
    angle_d = angle_q;
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    div_d   = div_q;
    manual  = 1'b0;
    div_inc = '0;

    period    = (slew_per_q == 8'd0) ? 8'd1 : slew_per_q;
    timer_inc = (timer_q == {TW{1'b1}}) ? timer_q : timer_q + TW'(1);
    now  = {in_data_i.halt, in_data_i.valve2_request, in_data_i.valve1_request,
            in_data_i.ignite, in_data_i.ready_req};
    rise = now & ~flags_q;
    raw[0] = in_data_i.angle1;
    raw[1] = in_data_i.angle2;

    case (in_data_i.cmd)
      tivs_pkg::CMD_TICK: begin
        for (int v = 0; v < NV; v++) begin
          if (pos_q[v] == tgt_q[v]) begin
            div_d[v] = '0;
          end else begin
            div_inc = div_q[v] + 8'd1;
            if (div_inc >= period) begin
              div_d[v] = '0;
              pos_d[v] = (pos_q[v] < tgt_q[v]) ? pos_q[v] + AW'(1) : pos_q[v] - AW'(1);
            end else begin
              div_d[v] = div_inc;
            end
          end
        end
        unique case (phase_q)
          tivs_pkg::PH_IGN_ON: begin
            timer_d = timer_inc;
            if (timer_inc >= ign_delay_q) begin
              for (int v = 0; v < NV; v++) begin
                tgt_d[v] = (angle_q[v] > max_angle_q) ? max_angle_q : angle_q[v];
              end
              phase_d = tivs_pkg::PH_OPENING;
            end
          end
          tivs_pkg::PH_OPENING: begin
            if (pos_d[0] == tgt_q[0] && pos_d[1] == tgt_q[1]) begin
              phase_d = tivs_pkg::PH_WAITING;
              timer_d = '0;
            end
          end
          tivs_pkg::PH_WAITING: begin
            timer_d = timer_inc;
            if (timer_inc >= burn_time_q) begin
              tgt_d[0] = '0;
              tgt_d[1] = '0;
              phase_d  = tivs_pkg::PH_CLOSING;
            end
          end
          tivs_pkg::PH_CLOSING: begin
            if (pos_d[0] == '0 && pos_d[1] == '0) begin
              phase_d = tivs_pkg::PH_COMPLETE;
            end
          end
          tivs_pkg::PH_COMPLETE: begin
            ign_d   = 1'b0;
            phase_d = tivs_pkg::PH_IDLE;
          end
          default: phase_d = tivs_pkg::PH_IDLE;
        endcase
      end
      tivs_pkg::CMD_RADIO: begin
        flags_d = now;
        for (int v = 0; v < NV; v++) begin
          angle_d[v] = (raw[v] > {{(16-AW){1'b0}}, max_angle_q}) ? max_angle_q
                                                                 : raw[v][AW-1:0];
        end
        if (link_q) begin
          if (rise[1] && now[0] && phase_q == tivs_pkg::PH_IDLE) begin
            fired_d = 1'b1;
            ign_d   = 1'b1;
            phase_d = tivs_pkg::PH_IGN_ON;
            timer_d = '0;
          end
          for (int v = 0; v < NV; v++) begin
            if (rise[2+v]) begin
              manual   = 1'b1;
              tgt_d[v] = (tgt_q[v] != '0) ? '0 : angle_d[v];
            end
          end
          // A manual valve edge during a running sequence aborts it.
          if (manual && phase_d != tivs_pkg::PH_IDLE) begin
            phase_d  = tivs_pkg::PH_IDLE;
            timer_d  = '0;
            fired_d  = 1'b0;
            ign_d    = 1'b0;
            tgt_d[0] = '0;
            tgt_d[1] = '0;
          end
        end
      end
      tivs_pkg::CMD_LINK: link_d = in_data_i.link_ok;
      default: ;
    endcase

    out_d.ignition_out    = ign_d;
    out_d.power_out       = link_d || fired_d || (phase_d != tivs_pkg::PH_IDLE);
    out_d.valve1_position = pos_d[0];
    out_d.valve2_position = pos_d[1];
    out_d.valve1_open     = (tgt_d[0] != '0);
    out_d.valve2_open     = (tgt_d[1] != '0);
    out_d.fired           = fired_d;
    out_d.ready_status    = flags_d[0];
    out_d.halt_status     = flags_d[4];
    out_d.phase           = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tivs_pkg::PH_IDLE;
      timer_q <= '0;
      link_q  <= 1'b0;
      flags_q <= '0;
      fired_q <= 1'b0;
      ign_q   <= 1'b0;
      for (int v = 0; v < NV; v++) begin
        angle_q[v] <= tivs_pkg::ANGLE_RST;
        pos_q[v]   <= '0;
        tgt_q[v]   <= '0;
        div_q[v]   <= '0;
      end
    end else if (accept) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      link_q  <= link_d;
      flags_q <= flags_d;
      fired_q <= fired_d;
      ign_q   <= ign_d;
      angle_q <= angle_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      div_q   <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  // Every accepted request yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  // The ignition line is only driven while a sequence is in progress.
  a_ign_in_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ign_q |-> (phase_q != tivs_pkg::PH_IDLE))
    else $error("ignition driven while idle");

  // A running sequence always has the fired latch set.
  a_fired_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != tivs_pkg::PH_IDLE) |-> fired_q)
    else $error("sequence running without fired latch");

  // A reported result agrees with the ignition and phase relation.
  a_result_ign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.ignition_out) |-> (out_data_o.phase != tivs_pkg::PH_IDLE))
    else $error("result shows ignition in idle phase");

endmodule
